FILE: design/wmbs_pkg.sv
// ----------------------------------------------------------------------------
// wmbs_pkg
// shared types, constants and the divider step of the windowed mean unit
// ----------------------------------------------------------------------------
package wmbs_pkg;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int CODE_W   = 4;
    localparam int SLOT_W   = 3;
    localparam int DIFF_W   = 17;
    localparam int STATUS_W = 2;
    localparam int WIN_W    = 12;

    // accumulator and divisor widths (windows hold at most 4096 positions)
    localparam int SUM_W    = 28;
    localparam int DEN_W    = WIN_W + 1;
    localparam int CNT_W    = $clog2(SUM_W);

    // configuration register file
    localparam int CFG_IDX_W = 2;

    // default parameter values
    localparam int DEF_MAX_WAVE_LEN = 4096;
    localparam int DEF_NUM_CHANNELS = 8;

    // item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIG_START = 2'd0,
        CFG_SIG_STOP  = 2'd1,
        CFG_BKG_START = 2'd2,
        CFG_BKG_STOP  = 2'd3
    } t_cfg_idx;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_UNKNOWN = 2'd2
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic in_ready;
        logic take;
        logic div_load;
        logic div_step;
        logic finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_valid;
        logic in_last;
        logic out_free;
    } t_sts;

    // restoring divider state: partial remainder and dividend/quotient shifter
    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [SUM_W-1:0] quo;
    } t_div;

    function automatic t_div div_step(input t_div cur, input logic [DEN_W-1:0] den);
        logic [DEN_W:0] sh;
        t_div           nxt;
        sh      = {cur.rem, cur.quo[SUM_W-1]};
        nxt.quo = {cur.quo[SUM_W-2:0], 1'b0};
        if (sh >= {1'b0, den}) begin
            nxt.rem    = DEN_W'(sh - {1'b0, den});
            nxt.quo[0] = 1'b1;
        end else begin
            nxt.rem = sh[DEN_W-1:0];
        end
        return nxt;
    endfunction

endpackage

FILE: design/wmbs_in_if.sv
// ----------------------------------------------------------------------------
// wmbs_in_if
// input channel: waveform samples and slot reads
// ----------------------------------------------------------------------------
interface wmbs_in_if;
    logic                                valid;
    logic                                ready;
    logic                                kind;
    logic signed [wmbs_pkg::SAMPLE_W-1:0] sample_value;
    logic [wmbs_pkg::CODE_W-1:0]         channel_code;
    logic                                last_sample;

    modport source (output valid, kind, sample_value, channel_code, last_sample,
                    input ready);
    modport sink   (input valid, kind, sample_value, channel_code, last_sample,
                    output ready);
endinterface

FILE: design/wmbs_out_if.sv
// ----------------------------------------------------------------------------
// wmbs_out_if
// result channel: slot, mean difference and status
// ----------------------------------------------------------------------------
interface wmbs_out_if;
    logic                                valid;
    logic                                ready;
    logic [wmbs_pkg::SLOT_W-1:0]         channel_slot;
    logic signed [wmbs_pkg::DIFF_W-1:0]  mean_difference;
    logic [wmbs_pkg::STATUS_W-1:0]       status;

    modport source (output valid, channel_slot, mean_difference, status,
                    input ready);
    modport sink   (input valid, channel_slot, mean_difference, status,
                    output ready);
endinterface

FILE: design/wmbs_ctrl.sv
// ----------------------------------------------------------------------------
// wmbs_ctrl
// sequencer: accumulate, load divider, iterate, deliver result
// ----------------------------------------------------------------------------
module wmbs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  wmbs_pkg::t_sts   i_sts,
    output wmbs_pkg::t_cmd   o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOAD = 4'b0010,
        S_DIV  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state                       r_state, n_state;
    logic [wmbs_pkg::CNT_W-1:0]   r_cnt, n_cnt;

    always_comb begin
        n_state         = r_state;
        n_cnt           = r_cnt;
        o_cmd           = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = i_sts.out_free;
                o_cmd.take     = i_sts.out_free && i_sts.in_valid;
                if (o_cmd.take && i_sts.in_last) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.div_load = 1'b1;
                n_cnt          = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == wmbs_pkg::CNT_W'(wmbs_pkg::SUM_W - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

FILE: design/wmbs_dp.sv
// ----------------------------------------------------------------------------
// wmbs_dp
// window sums, two restoring dividers, result store and output register
// ----------------------------------------------------------------------------
module wmbs_dp #(
    parameter int MAX_WAVE_LEN = wmbs_pkg::DEF_MAX_WAVE_LEN,
    parameter int NUM_CHANNELS = wmbs_pkg::DEF_NUM_CHANNELS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  wmbs_pkg::t_cmd                       i_cmd,
    output wmbs_pkg::t_sts                       o_sts,
    // input item
    input  logic                                 i_valid,
    input  logic                                 i_kind,
    input  logic signed [wmbs_pkg::SAMPLE_W-1:0] i_sample_value,
    input  logic [wmbs_pkg::CODE_W-1:0]          i_channel_code,
    input  logic                                 i_last_sample,
    // configuration writes
    input  logic                                 i_cfg_we,
    input  logic [wmbs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [wmbs_pkg::WIN_W-1:0]           i_cfg_data,
    // result item
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic [wmbs_pkg::SLOT_W-1:0]          o_channel_slot,
    output logic signed [wmbs_pkg::DIFF_W-1:0]   o_mean_difference,
    output logic [wmbs_pkg::STATUS_W-1:0]        o_status
);

    localparam int POS_W = $clog2(MAX_WAVE_LEN + 1);
    localparam int CMP_W = (POS_W > wmbs_pkg::WIN_W) ? POS_W : wmbs_pkg::WIN_W;
    localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int NCH_W = $clog2(NUM_CHANNELS + 1) + 1;
    localparam int SUM_W = wmbs_pkg::SUM_W;
    localparam int DEN_W = wmbs_pkg::DEN_W;
    localparam int WIN_W = wmbs_pkg::WIN_W;

    // configuration
    logic [WIN_W-1:0] r_sig_start, r_sig_stop, r_bkg_start, r_bkg_stop;

    // accumulation
    logic signed [SUM_W-1:0] r_sig_sum, r_bkg_sum;
    logic [POS_W-1:0]        r_pos;
    logic [wmbs_pkg::CODE_W-1:0] r_code;

    // dividers
    wmbs_pkg::t_div   r_sdiv, r_bdiv;
    logic [DEN_W-1:0] r_sden, r_bden;
    logic             r_sneg, r_bneg, r_empty;

    // result store
    logic signed [wmbs_pkg::DIFF_W-1:0] r_res [NUM_CHANNELS];

    // output register
    logic                               r_out_valid;
    logic [wmbs_pkg::SLOT_W-1:0]        r_slot;
    logic signed [wmbs_pkg::DIFF_W-1:0] r_diff;
    logic [wmbs_pkg::STATUS_W-1:0]      r_status;

    logic [CMP_W-1:0]        w_pos;
    logic                    w_pos_ok, w_in_sig, w_in_bkg;
    logic signed [SUM_W-1:0] w_sample;
    logic                    w_take_smp, w_take_rd;
    logic signed [SUM_W-1:0] w_qs, w_qb, w_dfull;
    logic [wmbs_pkg::SLOT_W-1:0] w_fslot;
    logic                    w_fbad;
    logic                    w_rd_ok;

    assign o_sts.in_valid = i_valid;
    assign o_sts.in_last  = (i_kind == wmbs_pkg::KIND_SAMPLE) && i_last_sample;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign w_take_smp = i_cmd.take && (i_kind == wmbs_pkg::KIND_SAMPLE);
    assign w_take_rd  = i_cmd.take && (i_kind == wmbs_pkg::KIND_READ);

    // window membership of the current position
    assign w_pos    = CMP_W'(r_pos);
    assign w_pos_ok = r_pos < POS_W'(MAX_WAVE_LEN);
    assign w_in_sig = (w_pos >= CMP_W'(r_sig_start)) && (w_pos <= CMP_W'(r_sig_stop));
    assign w_in_bkg = (w_pos >= CMP_W'(r_bkg_start)) && (w_pos <= CMP_W'(r_bkg_stop));
    assign w_sample = SUM_W'(i_sample_value);

    // signed quotients and their difference
    assign w_qs    = r_sneg ? -$signed(r_sdiv.quo) : $signed(r_sdiv.quo);
    assign w_qb    = r_bneg ? -$signed(r_bdiv.quo) : $signed(r_bdiv.quo);
    assign w_dfull = w_qs - w_qb;

    assign w_fslot = r_code[wmbs_pkg::CODE_W-1:1];
    assign w_fbad  = r_code[0] || (NCH_W'(w_fslot) >= NCH_W'(NUM_CHANNELS));
    assign w_rd_ok = NCH_W'(i_channel_code) < NCH_W'(NUM_CHANNELS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sig_start <= '0;
            r_sig_stop  <= '0;
            r_bkg_start <= '0;
            r_bkg_stop  <= '0;
        end else if (i_cfg_we) begin
            unique case (wmbs_pkg::t_cfg_idx'(i_cfg_index))
                wmbs_pkg::CFG_SIG_START: r_sig_start <= i_cfg_data;
                wmbs_pkg::CFG_SIG_STOP:  r_sig_stop  <= i_cfg_data;
                wmbs_pkg::CFG_BKG_START: r_bkg_start <= i_cfg_data;
                wmbs_pkg::CFG_BKG_STOP:  r_bkg_stop  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // accumulation, cleared when the divider takes the sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sig_sum <= '0;
            r_bkg_sum <= '0;
            r_pos     <= '0;
        end else if (i_cmd.div_load) begin
            r_sig_sum <= '0;
            r_bkg_sum <= '0;
            r_pos     <= '0;
        end else if (w_take_smp && w_pos_ok) begin
            if (w_in_sig) begin
                r_sig_sum <= r_sig_sum + w_sample;
            end
            if (w_in_bkg) begin
                r_bkg_sum <= r_bkg_sum + w_sample;
            end
            r_pos <= r_pos + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take_smp) begin
            r_code <= i_channel_code;
        end
    end

    // magnitude division, one quotient bit per cycle in both units
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_sdiv.rem <= '0;
            r_bdiv.rem <= '0;
            r_sdiv.quo <= r_sig_sum[SUM_W-1] ? $unsigned(-r_sig_sum) : $unsigned(r_sig_sum);
            r_bdiv.quo <= r_bkg_sum[SUM_W-1] ? $unsigned(-r_bkg_sum) : $unsigned(r_bkg_sum);
            r_sneg     <= r_sig_sum[SUM_W-1];
            r_bneg     <= r_bkg_sum[SUM_W-1];
            r_sden     <= DEN_W'({1'b0, r_sig_stop} - {1'b0, r_sig_start} + DEN_W'(1));
            r_bden     <= DEN_W'({1'b0, r_bkg_stop} - {1'b0, r_bkg_start} + DEN_W'(1));
            r_empty    <= (r_sig_stop < r_sig_start) || (r_bkg_stop < r_bkg_start);
        end else if (i_cmd.div_step) begin
            r_sdiv <= wmbs_pkg::div_step(r_sdiv, r_sden);
            r_bdiv <= wmbs_pkg::div_step(r_bdiv, r_bden);
        end
    end

    // per-slot results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_res[i] <= '0;
            end
        end else if (i_cmd.finish && !w_fbad) begin
            r_res[CH_W'(w_fslot)] <= r_empty ? '0 : w_dfull[wmbs_pkg::DIFF_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take_rd || i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take_rd) begin
            r_slot <= i_channel_code[wmbs_pkg::SLOT_W-1:0];
            if (w_rd_ok) begin
                r_diff   <= r_res[CH_W'(i_channel_code)];
                r_status <= wmbs_pkg::ST_OK;
            end else begin
                r_diff   <= '0;
                r_status <= wmbs_pkg::ST_UNKNOWN;
            end
        end else if (i_cmd.finish) begin
            r_diff   <= r_empty ? '0 : w_dfull[wmbs_pkg::DIFF_W-1:0];
            if (w_fbad) begin
                r_slot   <= '0;
                r_status <= wmbs_pkg::ST_UNKNOWN;
            end else begin
                r_slot   <= w_fslot;
                r_status <= r_empty ? wmbs_pkg::ST_EMPTY : wmbs_pkg::ST_OK;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_channel_slot    = r_slot;
    assign o_mean_difference = r_diff;
    assign o_status          = r_status;

endmodule

FILE: design/windowed_mean_background_subtract_unit.sv
// ----------------------------------------------------------------------------
// windowed_mean_background_subtract_unit
// boxcar signal mean minus background mean per waveform, stored per slot
// ----------------------------------------------------------------------------
// usage:
//   i_in carries one item per transfer: a waveform sample (kind 0) or a read
//   of a stored slot result (kind 1). o_out carries one result per last
//   sample and one per read. windows are set through i_cfg_we / i_cfg_index
//   / i_cfg_data; the user must write them only while the unit is idle,
//   which the unit does not enforce. samples that are not last stream in
//   at one sample per clock while the output register is free. a read
//   gives its result in the cycle after the transfer. the last sample
//   starts the two parallel restoring dividers (one quotient bit per cycle
//   over the 28-bit sums) via S_LOAD, S_DIV and S_FIN; S_FIN writes its
//   result once the output register is free, then the unit is idle again.
//   reset clears the window registers, the sums, the sample position and all
//   stored slot results; the first item is taken right after reset.
//   a single output register holds the result: while it is full and the
//   receiver stalls, i_in.ready stays low and the unit waits; a register
//   that is being drained in the same cycle counts as free.
// ----------------------------------------------------------------------------
module windowed_mean_background_subtract_unit #(
    parameter int MAX_WAVE_LEN = wmbs_pkg::DEF_MAX_WAVE_LEN,
    parameter int NUM_CHANNELS = wmbs_pkg::DEF_NUM_CHANNELS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    wmbs_in_if.sink                          i_in,
    wmbs_out_if.source                       o_out,
    input  logic                             i_cfg_we,
    input  logic [wmbs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [wmbs_pkg::WIN_W-1:0]       i_cfg_data
);

    // command and status between sequencer and datapath
    wmbs_pkg::t_cmd w_cmd;
    wmbs_pkg::t_sts w_sts;

    wmbs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    wmbs_dp #(
        .MAX_WAVE_LEN (MAX_WAVE_LEN),
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_valid           (i_in.valid),
        .i_kind            (i_in.kind),
        .i_sample_value    (i_in.sample_value),
        .i_channel_code    (i_in.channel_code),
        .i_last_sample     (i_in.last_sample),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_out_ready       (o_out.ready),
        .o_out_valid       (o_out.valid),
        .o_channel_slot    (o_out.channel_slot),
        .o_mean_difference (o_out.mean_difference),
        .o_status          (o_out.status)
    );

    // ready comes from the sequencer only in its idle state
    assign i_in.ready = w_cmd.in_ready;

`ifndef ASSERT_OFF
    // the transfer of a last sample hands the unit to the divider
    a_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && (i_in.kind == wmbs_pkg::KIND_SAMPLE)
         && i_in.last_sample) |=> !i_in.ready)
        else $error("input taken while the divider is busy");

    // a read transfer is answered in the next cycle
    a_read_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && (i_in.kind == wmbs_pkg::KIND_READ))
        |=> o_out.valid)
        else $error("read transfer without a result");

    // an empty window always reports zero
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status == wmbs_pkg::ST_EMPTY))
        |-> (o_out.mean_difference == '0))
        else $error("empty window result is not zero");
`endif

endmodule
